// ===== sv/rhvc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rolling historical VaR check: shared definitions
// Widths, defaults, register indexes, chain operations and controller states.
// ----------------------------------------------------------------------------
package rhvc_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int MIN_SAMPLES_DEF = 20;

  localparam int RET_W      = 32;
  localparam int EQ_W       = 48;
  localparam int LIMIT_W    = 48;
  localparam int CONF_W     = 16;
  localparam int LOOKBACK_W = 9;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 48;
  localparam int FRAC_W     = 24;
  localparam int PART_W     = 24;

  localparam logic [LOOKBACK_W-1:0] LOOKBACK_RST   = 9'd250;
  localparam logic [CONF_W-1:0]     CONFIDENCE_RST = 16'd62259;

  typedef logic signed [RET_W-1:0] ret_t;

  localparam ret_t RET_MIN = 32'sh8000_0000;
  localparam ret_t RET_MAX = 32'sh7fff_ffff;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LOOKBACK   = 3'd0,
    REG_CONFIDENCE = 3'd1,
    REG_LIMIT      = 3'd2,
    REG_ENABLE     = 3'd3,
    REG_CAPITAL    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    ret_t      operand;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELETE,
    ST_INSERT,
    ST_INDEX,
    ST_ROTATE,
    ST_MUL,
    ST_CMP
  } state_t;

endpackage

// ===== sv/rhvc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rhvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rhvc_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one return of the ascending window copy and its valid bit. Inserts,
// deletes and rotation take a word from a neighbour (or the operand on insert).
// ----------------------------------------------------------------------------
module rhvc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rhvc_pkg::chain_ctrl_t ctrl,
  input  rhvc_pkg::ret_t      left_val,
  input  logic                left_valid,
  input  logic                left_gt,
  input  rhvc_pkg::ret_t      right_val,
  input  logic                right_valid,
  output rhvc_pkg::ret_t      val,
  output logic                valid,
  output logic                gt
);
  import rhvc_pkg::*;

  ret_t val_r, val_nxt;
  logic valid_r, valid_nxt;
  logic del;

  always_comb begin
    // An empty cell counts as larger than anything, so the boundary is local.
    gt  = !valid_r || (val_r > $signed(ctrl.operand));
    del = !valid_r || (val_r >= $signed(ctrl.operand));
    val_nxt   = val_r;
    valid_nxt = valid_r;
    unique case (ctrl.op)
      OP_HOLD: begin
      end
      OP_INSERT: begin
        if (gt) begin
          if (left_gt) begin
            val_nxt   = left_val;
            valid_nxt = left_valid;
          end else begin
            val_nxt   = ctrl.operand;
            valid_nxt = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (del) begin
          val_nxt   = right_val;
          valid_nxt = right_valid;
        end
      end
      OP_ROTATE: begin
        val_nxt   = right_val;
        valid_nxt = right_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule

// ===== sv/rhvc_chain.sv =====
// ----------------------------------------------------------------------------
// Sorted window chain
// A row of cells keeping the window in ascending order. Rotation brings each
// entry in turn to the head cell.
// ----------------------------------------------------------------------------
module rhvc_chain #(
  parameter int DEPTH = rhvc_pkg::MAX_WINDOW_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rhvc_pkg::chain_ctrl_t ctrl,
  output rhvc_pkg::ret_t        head_val
);
  import rhvc_pkg::*;

  ret_t val   [DEPTH];
  logic valid [DEPTH];
  logic gt    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ret_t lv, rv;
    logic lvalid, lgt, rvalid;

    if (i == 0) begin : g_first
      assign lv     = '0;
      assign lvalid = 1'b0;
      assign lgt    = 1'b0;
    end else begin : g_inner_l
      assign lv     = val[i-1];
      assign lvalid = valid[i-1];
      assign lgt    = gt[i-1];
    end

    // The last cell closes the ring only while rotating.
    if (i == DEPTH-1) begin : g_last
      assign rv     = val[0];
      assign rvalid = (ctrl.op == OP_ROTATE) ? valid[0] : 1'b0;
    end else begin : g_inner_r
      assign rv     = val[i+1];
      assign rvalid = valid[i+1];
    end

    rhvc_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .left_val    (lv),
      .left_valid  (lvalid),
      .left_gt     (lgt),
      .right_val   (rv),
      .right_valid (rvalid),
      .val         (val[i]),
      .valid       (valid[i]),
      .gt          (gt[i])
    );
  end

  assign head_val = val[0];

endmodule

// ===== sv/rolling_historical_var_check.sv =====
// ----------------------------------------------------------------------------
// Rolling historical value-at-risk check
// Keeps a rolling window of returns, selects the quantile return and flags
// a breach of the VaR-to-equity limit.
// ----------------------------------------------------------------------------
// Flow: an accepted word passes the delete step (only when an entry is dropped),
// insert, index, a full rotation of the sorted cell chain, the multiply steps and
// the compare. One word is handled at a time: a new word is taken only when idle,
// and a result still waiting holds the controller in its last state.
// Reset clears the window count, the oldest pointer, cell valid bits and the
// result valid flag and sets the configuration registers to their defaults;
// the return store itself is not cleared.
module rolling_historical_var_check #(
  parameter int MAX_WINDOW  = rhvc_pkg::MAX_WINDOW_DEF,
  parameter int MIN_SAMPLES = rhvc_pkg::MIN_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rhvc_pkg::RET_W-1:0]   in_period_return,
  input  logic signed [rhvc_pkg::EQ_W-1:0]    in_equity_now,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rhvc_pkg::RET_W-1:0]   out_var_value,
  output logic                                out_window_ready,
  output logic                                out_limit_breached,
  input  logic                                cfg_we,
  input  logic [rhvc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rhvc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import rhvc_pkg::*;

  localparam int PTR_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int INV_W     = CONF_W + 1;
  localparam int PROD_W    = INV_W + CNT_W;
  localparam int ACC_W     = 2 * LIMIT_W;
  localparam int PP_W      = 2 * PART_W;
  localparam int MUL_STEPS = 4;

  // Configuration registers
  logic [LOOKBACK_W-1:0]  cfg_lookback_r;
  logic [CONF_W-1:0]      cfg_conf_r;
  logic [LIMIT_W-1:0]     cfg_limit_r;
  logic                   cfg_enable_r;
  logic signed [EQ_W-1:0] cfg_capital_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lookback_r <= LOOKBACK_RST;
      cfg_conf_r     <= CONFIDENCE_RST;
      cfg_limit_r    <= '0;
      cfg_enable_r   <= 1'b0;
      cfg_capital_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_LOOKBACK:   cfg_lookback_r <= cfg_wdata[LOOKBACK_W-1:0];
        REG_CONFIDENCE: cfg_conf_r     <= cfg_wdata[CONF_W-1:0];
        REG_LIMIT:      cfg_limit_r    <= cfg_wdata[LIMIT_W-1:0];
        REG_ENABLE:     cfg_enable_r   <= cfg_wdata[0];
        REG_CAPITAL:    cfg_capital_r  <= $signed(cfg_wdata[EQ_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Datapath and control registers
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [PTR_W-1:0]       oldest_r, oldest_nxt;
  ret_t                   ret_r, ret_nxt;
  logic signed [EQ_W-1:0] eq_r, eq_nxt;
  logic [PTR_W-1:0]       wr_addr_r, wr_addr_nxt;
  logic                   drop_r, drop_nxt;
  logic [PTR_W-1:0]       idx_r, idx_nxt;
  logic [PTR_W-1:0]       rot_r, rot_nxt;
  ret_t                   sel_r, sel_nxt;
  logic signed [EQ_W-1:0] eq_eff_r, eq_eff_nxt;
  logic [2:0]             step_r, step_nxt;
  logic [PP_W-1:0]        pp_r, pp_nxt;
  logic [1:0]             pp_sh_r, pp_sh_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  ret_t                   out_var_r, out_var_nxt;
  logic                   out_rdy_r, out_rdy_nxt;
  logic                   out_brk_r, out_brk_nxt;

  // Window arithmetic
  logic [31:0]         lb32, eff32;
  logic                drop_now;
  logic [CNT_W:0]      wsum;
  logic [PTR_W-1:0]    wr_addr_now;
  logic [INV_W-1:0]    inv_conf;
  logic [PROD_W-1:0]   prod;
  logic [CNT_W:0]      idx_raw, count_m1;

  always_comb begin
    lb32  = 32'(cfg_lookback_r);
    eff32 = (lb32 < 32'(MIN_SAMPLES)) ? 32'(MIN_SAMPLES) : lb32;
    if (eff32 > 32'(MAX_WINDOW)) begin
      eff32 = 32'(MAX_WINDOW);
    end
    // A full store always drops, since the effective lookback never exceeds it.
    drop_now = 32'(count_r) >= eff32;
    wsum     = (CNT_W+1)'(oldest_r) + (CNT_W+1)'(count_r);
    wr_addr_now = (wsum >= (CNT_W+1)'(MAX_WINDOW)) ?
                  PTR_W'(wsum - (CNT_W+1)'(MAX_WINDOW)) : PTR_W'(wsum);
    inv_conf = INV_W'(1 << CONF_W) - INV_W'(cfg_conf_r);
    prod     = PROD_W'(inv_conf) * PROD_W'(count_r);
    idx_raw  = prod[PROD_W-1:CONF_W];
    count_m1 = (CNT_W+1)'(count_r) - (CNT_W+1)'(1);
  end

  // Return store in arrival order
  logic [RET_W-1:0] ram_rdata;
  logic             ram_re, ram_we;

  rhvc_ram #(
    .WIDTH (RET_W),
    .DEPTH (MAX_WINDOW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr_r),
    .wdata (ret_r),
    .re    (ram_re),
    .raddr (oldest_r),
    .rdata (ram_rdata)
  );

  // Sorted copy of the window
  chain_ctrl_t chain_ctrl;
  ret_t        head_val;

  rhvc_chain #(
    .DEPTH (MAX_WINDOW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (chain_ctrl),
    .head_val (head_val)
  );

  // Result arithmetic
  logic              ready_now;
  ret_t              var_sat;
  logic [63:0]       lhs;
  logic [PART_W-1:0] a_part, b_part;
  logic [EQ_W-1:0]   eq_u;

  always_comb begin
    ready_now = 32'(count_r) >= 32'(MIN_SAMPLES);
    var_sat   = (sel_r == RET_MIN) ? RET_MAX : -sel_r;
    lhs       = {8'b0, var_sat, 24'b0};
    eq_u      = eq_eff_r;
    a_part    = '0;
    b_part    = '0;
    unique case (step_r[1:0])
      2'd0: begin a_part = cfg_limit_r[PART_W-1:0];       b_part = eq_u[PART_W-1:0];       end
      2'd1: begin a_part = cfg_limit_r[PART_W-1:0];       b_part = eq_u[EQ_W-1:PART_W];    end
      2'd2: begin a_part = cfg_limit_r[LIMIT_W-1:PART_W]; b_part = eq_u[PART_W-1:0];       end
      2'd3: begin a_part = cfg_limit_r[LIMIT_W-1:PART_W]; b_part = eq_u[EQ_W-1:PART_W];    end
      default: begin
      end
    endcase
  end

  // Controller
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    ret_nxt       = ret_r;
    eq_nxt        = eq_r;
    wr_addr_nxt   = wr_addr_r;
    drop_nxt      = drop_r;
    idx_nxt       = idx_r;
    rot_nxt       = rot_r;
    sel_nxt       = sel_r;
    eq_eff_nxt    = eq_eff_r;
    step_nxt      = step_r;
    pp_nxt        = pp_r;
    pp_sh_nxt     = pp_sh_r;
    acc_nxt       = acc_r;
    out_var_nxt   = out_var_r;
    out_rdy_nxt   = out_rdy_r;
    out_brk_nxt   = out_brk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    chain_ctrl    = '{op: OP_HOLD, operand: '0};

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ret_nxt     = in_period_return;
          eq_nxt      = in_equity_now;
          drop_nxt    = drop_now;
          wr_addr_nxt = wr_addr_now;
          // The oldest word is read before its slot may be overwritten.
          ram_re      = drop_now;
          state_nxt   = drop_now ? ST_DELETE : ST_INSERT;
        end
      end
      ST_DELETE: begin
        chain_ctrl = '{op: OP_DELETE, operand: $signed(ram_rdata)};
        oldest_nxt = (oldest_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : oldest_r + PTR_W'(1);
        state_nxt  = ST_INSERT;
      end
      ST_INSERT: begin
        chain_ctrl = '{op: OP_INSERT, operand: ret_r};
        ram_we     = 1'b1;
        count_nxt  = drop_r ? count_r : count_r + CNT_W'(1);
        state_nxt  = ST_INDEX;
      end
      ST_INDEX: begin
        idx_nxt    = (idx_raw > count_m1) ? PTR_W'(count_m1) : PTR_W'(idx_raw);
        eq_eff_nxt = (eq_r > 48'sd0) ? eq_r : cfg_capital_r;
        rot_nxt    = '0;
        state_nxt  = ST_ROTATE;
      end
      ST_ROTATE: begin
        // After j shifts the head cell holds the j-th smallest entry.
        chain_ctrl = '{op: OP_ROTATE, operand: '0};
        if (rot_r == idx_r) begin
          sel_nxt = head_val;
        end
        rot_nxt = rot_r + PTR_W'(1);
        if (rot_r == PTR_W'(MAX_WINDOW - 1)) begin
          step_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        pp_nxt    = PP_W'(a_part) * PP_W'(b_part);
        pp_sh_nxt = 2'(step_r[0]) + 2'(step_r[1]);
        if (step_r != 3'd0) begin
          unique case (pp_sh_r)
            2'd0:    acc_nxt = acc_r + ACC_W'(pp_r);
            2'd1:    acc_nxt = acc_r + (ACC_W'(pp_r) << PART_W);
            2'd2:    acc_nxt = acc_r + (ACC_W'(pp_r) << (2 * PART_W));
            default: acc_nxt = acc_r;
          endcase
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'(MUL_STEPS)) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rdy_nxt   = ready_now;
          out_var_nxt   = ready_now ? var_sat : '0;
          out_brk_nxt   = ready_now && cfg_enable_r && (eq_eff_r > 48'sd0) &&
                          (var_sat > 32'sd0) && (acc_r[ACC_W-1:64] == '0) &&
                          (lhs > acc_r[63:0]);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r     <= ret_nxt;
    eq_r      <= eq_nxt;
    wr_addr_r <= wr_addr_nxt;
    drop_r    <= drop_nxt;
    idx_r     <= idx_nxt;
    rot_r     <= rot_nxt;
    sel_r     <= sel_nxt;
    eq_eff_r  <= eq_eff_nxt;
    step_r    <= step_nxt;
    pp_r      <= pp_nxt;
    pp_sh_r   <= pp_sh_nxt;
    acc_r     <= acc_nxt;
    out_var_r <= out_var_nxt;
    out_rdy_r <= out_rdy_nxt;
    out_brk_r <= out_brk_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_var_value      = out_var_r;
  assign out_window_ready   = out_rdy_r;
  assign out_limit_breached = out_brk_r;

endmodule

// ===== sv/rhvc_checker.sv =====
// ----------------------------------------------------------------------------
// Rolling historical VaR check: port checker
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
module rhvc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [rhvc_pkg::RET_W-1:0] out_var_value,
  input logic                              out_window_ready,
  input logic                              out_limit_breached
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_var_value) &&
      $stable(out_window_ready) && $stable(out_limit_breached))
    else $error("result word changed while stalled");

  // A short window reports zero VaR and never a breach.
  a_short_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_ready |-> out_var_value == '0 && !out_limit_breached)
    else $error("short window reported a non-zero result");

  // A breach needs a ready window (at least the minimum samples) and a positive VaR.
  a_breach_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_limit_breached |-> out_window_ready && out_var_value > 0)
    else $error("breach flagged without positive VaR");

  // The block is busy in the cycle after taking a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted back to back");

endmodule

bind rolling_historical_var_check rhvc_checker u_rhvc_checker (.*);
